FILE: rtl/cfa_subpath_log_compressor_unit_defines.svh
// Assertion macros shared by the sub-path log compressor modules.
`ifndef CFA_SUBPATH_LOG_COMPRESSOR_UNIT_DEFINES_SVH
`define CFA_SUBPATH_LOG_COMPRESSOR_UNIT_DEFINES_SVH

// A condition that holds at every clock edge outside reset.
`define CFA_SLC_ASSERT(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// A condition that must hold in the cycle after its antecedent.
`define CFA_SLC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/cfa_slc_pkg.sv
// Types, codes and defaults shared by the sub-path log compressor.
`default_nettype none
package cfa_slc_pkg;

   localparam int DEF_NUM_PATTERNS    = 8;
   localparam int DEF_MAX_PATTERN_LEN = 6;
   localparam int DEF_LOG_DEPTH       = 4096;

   localparam logic [31:0] COUNTER_START = 32'hffff0002;

   localparam logic [1:0] OP_TRACE   = 2'd0;
   localparam logic [1:0] OP_TABLE   = 2'd1;
   localparam logic [1:0] OP_RESTART = 2'd2;

   localparam logic [2:0] SLOT_LEN = 3'd6;
   localparam logic [2:0] SLOT_ID  = 3'd7;

   localparam logic [2:0] KIND_NONE     = 3'd0;
   localparam logic [2:0] KIND_TRACE    = 3'd1;
   localparam logic [2:0] KIND_SET_WORD = 3'd2;
   localparam logic [2:0] KIND_SET_LEN  = 3'd3;
   localparam logic [2:0] KIND_SET_ID   = 3'd4;
   localparam logic [2:0] KIND_RESTART  = 3'd5;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] addr;
      logic [2:0]  pat_index;
      logic [2:0]  pat_slot;
   } req_word_type;

   typedef struct packed {
      logic        log_write;
      logic [11:0] log_index;
      logic [31:0] log_value;
   } rsp_word_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] addr;
      logic [2:0]  pat_index;
      logic [2:0]  pat_slot;
   } cmd_type;

   typedef struct packed {
      logic        trace;
      logic        restart;
      logic        compress;
      logic [31:0] addr;
      logic        hit;
      logic [2:0]  hit_len;
      logic [31:0] hit_id;
      logic        mon_zero;
   } stage_type;

endpackage
`default_nettype wire

FILE: rtl/cfa_slc_front.sv
// Front end: accepts request words, classifies them and queues them for the back end.
`default_nettype none
`include "cfa_subpath_log_compressor_unit_defines.svh"
module cfa_slc_front
   import cfa_slc_pkg::*;
#(
   parameter int NUM_PATTERNS    = DEF_NUM_PATTERNS,
   parameter int MAX_PATTERN_LEN = DEF_MAX_PATTERN_LEN
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_word_type req_word,
   output logic              head_valid,
   output cmd_type           head,
   input  wire logic         pop
);

   cmd_type    entries_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   cmd_type    cmd;

   always_comb begin
      cmd.addr      = req_word.addr;
      cmd.pat_index = req_word.pat_index;
      cmd.pat_slot  = req_word.pat_slot;
      case (req_word.op)
         OP_TRACE: begin
            cmd.kind = KIND_TRACE;
         end
         OP_TABLE: begin
            if ({29'd0, req_word.pat_index} >= 32'(NUM_PATTERNS)) begin
               cmd.kind = KIND_NONE;
            end else if (req_word.pat_slot == SLOT_ID) begin
               cmd.kind = KIND_SET_ID;
            end else if (req_word.pat_slot == SLOT_LEN) begin
               cmd.kind = KIND_SET_LEN;
            end else if ({29'd0, req_word.pat_slot} < 32'(MAX_PATTERN_LEN)) begin
               cmd.kind = KIND_SET_WORD;
            end else begin
               cmd.kind = KIND_NONE;
            end
         end
         OP_RESTART: begin
            cmd.kind = KIND_RESTART;
         end
         default: begin
            cmd.kind = KIND_NONE;
         end
      endcase
   end

   assign req_stall  = (count_ff == 2'd2);
   assign push       = req_valid && !req_stall;
   assign head_valid = (count_ff != 2'd0);
   assign head       = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= cmd;
      end
   end

   `CFA_SLC_ASSERT(a_front_depth, count_ff != 2'd3, "Queue holds more than two words.")
   `CFA_SLC_ASSERT_NEXT(a_front_fill, push && !pop, count_ff == $past(count_ff) + 2'd1,
      "Queue count did not follow a lone push.")

endmodule
`default_nettype wire

FILE: rtl/cfa_slc_match.sv
// Back end first stage: pattern table and sub-path matching across all patterns.
`default_nettype none
`include "cfa_subpath_log_compressor_unit_defines.svh"
module cfa_slc_match
   import cfa_slc_pkg::*;
#(
   parameter int NUM_PATTERNS    = DEF_NUM_PATTERNS,
   parameter int MAX_PATTERN_LEN = DEF_MAX_PATTERN_LEN
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    compress_enable,
   input  wire logic    head_valid,
   input  wire cmd_type head,
   output logic         pop,
   output logic         out_valid,
   output stage_type    out_word,
   input  wire logic    out_ready
);

   localparam int IdxW = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;
   localparam int SlotW = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;

   logic [31:0] words_ff [NUM_PATTERNS][MAX_PATTERN_LEN];
   logic [31:0] ids_ff [NUM_PATTERNS];
   logic [NUM_PATTERNS-1:0][2:0] len_ff, len_in;
   logic [NUM_PATTERNS-1:0][2:0] prog_ff, prog_in;
   logic [NUM_PATTERNS-1:0]      mon_ff, mon_in;
   logic                         valid_ff, valid_in;
   stage_type                    stage_ff, stage_in;

   logic [NUM_PATTERNS-1:0]      eq_cur, eq_first;
   logic [NUM_PATTERNS-1:0][2:0] nxt_prog;
   logic [NUM_PATTERNS-1:0]      nxt_mon;
   logic                         done;
   logic [IdxW-1:0]              last;
   logic [IdxW-1:0]              wr_idx;
   logic [2:0]                   sat_len;

   assign pop       = head_valid && (!valid_ff || out_ready);
   assign out_valid = valid_ff;
   assign out_word  = stage_ff;
   assign wr_idx    = head.pat_index[IdxW-1:0];
   assign sat_len   = (head.addr > 32'(MAX_PATTERN_LEN)) ? 3'(MAX_PATTERN_LEN) : head.addr[2:0];

   always_comb begin
      logic [2:0] k;
      for (int i = 0; i < NUM_PATTERNS; i++) begin
         k = (prog_ff[i] >= 3'(MAX_PATTERN_LEN)) ? 3'(MAX_PATTERN_LEN - 1) : prog_ff[i];
         eq_cur[i]   = (head.addr == words_ff[i][k[SlotW-1:0]]);
         eq_first[i] = (head.addr == words_ff[i][0]);
      end
   end

   always_comb begin
      logic [2:0] p1;
      logic [2:0] np;
      logic       nm;
      logic       comp;
      done     = 1'b0;
      last     = '0;
      nxt_prog = prog_ff;
      nxt_mon  = mon_ff;
      for (int i = 0; i < NUM_PATTERNS; i++) begin
         p1 = prog_ff[i] + 3'd1;
         if (done) begin
            np   = eq_first[i] ? 3'd1 : 3'd0;
            nm   = eq_first[i];
            comp = eq_first[i] && (len_ff[i] == 3'd1);
         end else if (eq_cur[i]) begin
            np   = p1;
            nm   = 1'b1;
            comp = (p1 == len_ff[i]);
         end else if (mon_ff[i]) begin
            np   = eq_first[i] ? 3'd1 : 3'd0;
            nm   = eq_first[i];
            comp = 1'b0;
         end else begin
            np   = prog_ff[i];
            nm   = 1'b0;
            comp = 1'b0;
         end
         if (len_ff[i] != 3'd0) begin
            nxt_prog[i] = np;
            nxt_mon[i]  = nm;
            if (comp) begin
               done = 1'b1;
               last = IdxW'(i);
            end
         end
      end
      for (int j = 0; j < NUM_PATTERNS; j++) begin
         if (done && (IdxW'(j) <= last)) begin
            nxt_prog[j] = 3'd0;
            nxt_mon[j]  = 1'b0;
         end
      end
   end

   always_comb begin
      len_in   = len_ff;
      prog_in  = prog_ff;
      mon_in   = mon_ff;
      valid_in = pop ? 1'b1 : (out_ready ? 1'b0 : valid_ff);
      stage_in.trace    = (head.kind == KIND_TRACE);
      stage_in.restart  = (head.kind == KIND_RESTART);
      stage_in.compress = compress_enable;
      stage_in.addr     = head.addr;
      stage_in.hit      = compress_enable && done;
      stage_in.hit_len  = len_ff[last];
      stage_in.hit_id   = ids_ff[last];
      stage_in.mon_zero = (nxt_mon == '0);
      if (pop) begin
         case (head.kind)
            KIND_TRACE: begin
               if (compress_enable) begin
                  prog_in = nxt_prog;
                  mon_in  = nxt_mon;
               end
            end
            KIND_SET_LEN: begin
               len_in[wr_idx]  = sat_len;
               prog_in[wr_idx] = 3'd0;
               mon_in[wr_idx]  = 1'b0;
            end
            KIND_RESTART: begin
               prog_in = '0;
               mon_in  = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff   <= '0;
         prog_ff  <= '0;
         mon_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         len_ff   <= len_in;
         prog_ff  <= prog_in;
         mon_ff   <= mon_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         stage_ff <= stage_in;
      end
      if (pop && (head.kind == KIND_SET_WORD)) begin
         words_ff[wr_idx][head.pat_slot[SlotW-1:0]] <= head.addr;
      end
      if (pop && (head.kind == KIND_SET_ID)) begin
         ids_ff[wr_idx] <= head.addr;
      end
   end

   `CFA_SLC_ASSERT_NEXT(a_match_restart, pop && (head.kind == KIND_RESTART),
      (mon_ff == '0) && (prog_ff == '0), "Restart left match progress behind.")
   `CFA_SLC_ASSERT_NEXT(a_match_bypass, pop && (head.kind == KIND_TRACE) && !compress_enable,
      prog_ff == $past(prog_ff), "Progress moved with compression off.")

endmodule
`default_nettype wire

FILE: rtl/cfa_slc_log.sv
// Back end second stage: log position, sub-path rewind and repeat counting.
`default_nettype none
`include "cfa_subpath_log_compressor_unit_defines.svh"
module cfa_slc_log
   import cfa_slc_pkg::*;
#(
   parameter int LOG_DEPTH = DEF_LOG_DEPTH
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      in_valid,
   input  wire stage_type in_word,
   output logic           in_ready,
   output logic           rsp_valid,
   input  wire logic      rsp_stall,
   output rsp_word_type   rsp_word
);

   localparam int PosW = $clog2(LOG_DEPTH);
   localparam logic [PosW+1:0] Depth  = (PosW + 2)'(LOG_DEPTH);
   localparam logic [PosW+1:0] Depth2 = (PosW + 2)'(2 * LOG_DEPTH);

   logic [PosW-1:0] pos_ff, pos_in;
   logic            repeating_ff, repeating_in;
   logic [31:0]     counter_ff, counter_in;
   logic [31:0]     last_id_ff, last_id_in;
   logic [PosW-1:0] last_pos_ff, last_pos_in;
   logic            valid_ff, valid_in;
   rsp_word_type    rsp_ff, rsp_in;

   logic            load;
   logic [PosW+1:0] pos_x, len_x;
   logic [PosW-1:0] active;
   logic [PosW-1:0] pos_next, pos_back, last_next;
   logic            same;
   logic [PosW+11:0] index_x;

   function automatic logic [PosW-1:0] wrap(input logic [PosW+1:0] t);
      logic [PosW+1:0] r;
      if (t >= Depth2) begin
         r = t - Depth2;
      end else if (t >= Depth) begin
         r = t - Depth;
      end else begin
         r = t;
      end
      return r[PosW-1:0];
   endfunction

   assign in_ready  = !valid_ff || !rsp_stall;
   assign load      = in_valid && in_ready;
   assign rsp_valid = valid_ff;
   assign rsp_word  = rsp_ff;

   assign pos_x     = {2'b00, pos_ff};
   assign len_x     = (PosW + 2)'(in_word.hit_len);
   assign active    = wrap(pos_x + Depth + (PosW + 2)'(2) - len_x);
   assign pos_back  = wrap(pos_x + Depth + (PosW + 2)'(1) - len_x);
   assign pos_next  = wrap(pos_x + (PosW + 2)'(1));
   assign last_next = wrap({2'b00, last_pos_ff} + (PosW + 2)'(1));
   assign same      = (last_id_ff == in_word.hit_id) && (last_next == active);

   always_comb begin
      logic [31:0] val;
      pos_in       = pos_ff;
      repeating_in = repeating_ff;
      counter_in   = counter_ff;
      last_id_in   = last_id_ff;
      last_pos_in  = last_pos_ff;
      val          = 32'd0;
      valid_in     = load ? 1'b1 : (rsp_stall ? valid_ff : 1'b0);
      if (in_word.trace) begin
         if (!in_word.hit) begin
            pos_in = pos_next;
            val    = in_word.addr;
            if (in_word.compress && in_word.mon_zero) begin
               repeating_in = 1'b0;
               counter_in   = COUNTER_START;
            end
         end else if (!repeating_ff && !same) begin
            pos_in      = active;
            val         = in_word.hit_id;
            last_id_in  = in_word.hit_id;
            last_pos_in = active;
         end else if (!repeating_ff) begin
            repeating_in = 1'b1;
            pos_in       = active;
            last_pos_in  = last_next;
            val          = counter_ff;
         end else if (same) begin
            counter_in = counter_ff + 32'd1;
            pos_in     = pos_back;
            val        = counter_ff + 32'd1;
         end else begin
            repeating_in = 1'b0;
            counter_in   = COUNTER_START;
            pos_in       = active;
            val          = in_word.hit_id;
            last_id_in   = in_word.hit_id;
            last_pos_in  = active;
         end
      end else if (in_word.restart) begin
         pos_in       = '0;
         repeating_in = 1'b0;
         counter_in   = COUNTER_START;
         last_id_in   = 32'd0;
         last_pos_in  = '0;
      end
      index_x          = {12'd0, pos_in};
      rsp_in.log_write = in_word.trace;
      rsp_in.log_index = index_x[11:0];
      rsp_in.log_value = val;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         repeating_ff <= 1'b0;
         counter_ff   <= COUNTER_START;
         last_id_ff   <= 32'd0;
         last_pos_ff  <= '0;
         valid_ff     <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (load) begin
            pos_ff       <= pos_in;
            repeating_ff <= repeating_in;
            counter_ff   <= counter_in;
            last_id_ff   <= last_id_in;
            last_pos_ff  <= last_pos_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   `CFA_SLC_ASSERT(a_log_quiet, !(valid_ff && !rsp_ff.log_write) || (rsp_ff.log_value == 32'd0),
      "A word without a log write carries a value.")

endmodule
`default_nettype wire

FILE: rtl/cfa_subpath_log_compressor_unit.sv
// Top level of the control-flow log writer with sub-path compression.
// One word is taken per clock cycle while neither side stalls. Each word is registered in
// the two-word input queue, then after the eight parallel pattern comparators and their
// priority chain, then after the log position and repeat counter update. Queue and output
// registers let either side stall on its own. The one configuration bit turns compression
// on; the user must write it only while the block is idle; the block does not enforce this.
`default_nettype none
module cfa_subpath_log_compressor_unit
   import cfa_slc_pkg::*;
#(
   parameter int NUM_PATTERNS    = DEF_NUM_PATTERNS,
   parameter int MAX_PATTERN_LEN = DEF_MAX_PATTERN_LEN,
   parameter int LOG_DEPTH       = DEF_LOG_DEPTH
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_write_enable,
   input  wire logic         csr_write_data,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_word_type req_word,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_word_type      rsp_word
);

   logic      compress_ff, compress_in;
   logic      head_valid;
   cmd_type   head;
   logic      pop;
   logic      stage_valid;
   stage_type stage_word;
   logic      stage_ready;

   assign compress_in = csr_write_enable ? csr_write_data : compress_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         compress_ff <= 1'b0;
      end else begin
         compress_ff <= compress_in;
      end
   end

   cfa_slc_front #(
      .NUM_PATTERNS    (NUM_PATTERNS),
      .MAX_PATTERN_LEN (MAX_PATTERN_LEN)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_word   (req_word),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop)
   );

   cfa_slc_match #(
      .NUM_PATTERNS    (NUM_PATTERNS),
      .MAX_PATTERN_LEN (MAX_PATTERN_LEN)
   ) u_match (
      .clock           (clock),
      .reset           (reset),
      .compress_enable (compress_ff),
      .head_valid      (head_valid),
      .head            (head),
      .pop             (pop),
      .out_valid       (stage_valid),
      .out_word        (stage_word),
      .out_ready       (stage_ready)
   );

   cfa_slc_log #(
      .LOG_DEPTH (LOG_DEPTH)
   ) u_log (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (stage_valid),
      .in_word   (stage_word),
      .in_ready  (stage_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule
`default_nettype wire

FILE: bench/cfa_subpath_log_compressor_checker.sv
// Checker that predicts and compares the log words of the sub-path log compressor.
`timescale 1ns / 1ps
module cfa_subpath_log_compressor_checker
   import cfa_slc_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_write_enable,
   input  wire logic         csr_write_data,
   input  wire logic         req_valid,
   input  wire logic         req_stall,
   input  wire req_word_type req_word,
   input  wire logic         rsp_valid,
   input  wire logic         rsp_stall,
   input  wire rsp_word_type rsp_word,
   output int                error_count,
   output int                pending_count
);

   logic [31:0]  trk_words [8][6];
   logic [2:0]   trk_len [8];
   logic [31:0]  trk_id [8];
   logic [2:0]   trk_prog [8];
   logic [7:0]   trk_monitor;
   logic         trk_repeating;
   logic [31:0]  trk_counter;
   logic [31:0]  trk_last_id;
   logic [11:0]  trk_last_pos;
   logic [11:0]  trk_pos;
   logic         compress_on;
   rsp_word_type log_words_due [$];

   function automatic void clear_session();
      for (int i = 0; i < 8; i++) trk_prog[i] = '0;
      trk_monitor = '0;
      trk_repeating = 1'b0;
      trk_counter = COUNTER_START;
      trk_last_id = '0;
      trk_last_pos = '0;
   endfunction

   function automatic rsp_word_type log_word_for(req_word_type w);
      rsp_word_type r;
      int           hit;
      logic [2:0]   len;
      logic [31:0]  id;
      logic [11:0]  active;
      logic         same;
      r = '0;
      hit = -1;
      if (w.op == OP_TRACE) begin
         if (compress_on) begin
            for (int i = 0; i < 8; i++) begin
               if (trk_len[i] != 0) begin
                  if (w.addr == trk_words[i][trk_prog[i]]) begin
                     trk_prog[i] = trk_prog[i] + 3'd1;
                     trk_monitor[i] = 1'b1;
                     if (trk_prog[i] == trk_len[i]) begin
                        hit = i;
                        trk_monitor = '0;
                        for (int j = 0; j < 8; j++) trk_prog[j] = '0;
                     end
                  end else if (trk_monitor[i]) begin
                     if (w.addr == trk_words[i][0]) begin
                        trk_prog[i] = 3'd1;
                     end else begin
                        trk_monitor[i] = 1'b0;
                        trk_prog[i] = '0;
                     end
                  end
               end
            end
         end
         r.log_write = 1'b1;
         if (hit < 0) begin
            trk_pos = trk_pos + 12'd1;
            r.log_value = w.addr;
            if (compress_on && trk_monitor == 0) begin
               trk_repeating = 1'b0;
               trk_counter = COUNTER_START;
            end
         end else begin
            len = trk_len[hit];
            id = trk_id[hit];
            active = trk_pos + 12'd2 - 12'(len);
            same = (trk_last_id == id) && (trk_last_pos + 12'd1 == active);
            if (!trk_repeating && !same) begin
               trk_pos = active;
               r.log_value = id;
               trk_last_id = id;
               trk_last_pos = active;
            end else if (!trk_repeating) begin
               trk_repeating = 1'b1;
               trk_pos = active;
               trk_last_pos = trk_last_pos + 12'd1;
               r.log_value = trk_counter;
            end else if (same) begin
               trk_counter = trk_counter + 32'd1;
               trk_pos = trk_pos + 12'd1 - 12'(len);
               r.log_value = trk_counter;
            end else begin
               trk_repeating = 1'b0;
               trk_counter = COUNTER_START;
               trk_pos = active;
               r.log_value = id;
               trk_last_id = id;
               trk_last_pos = active;
            end
         end
      end else if (w.op == OP_TABLE) begin
         if (w.pat_slot == SLOT_ID) begin
            trk_id[w.pat_index] = w.addr;
         end else if (w.pat_slot == SLOT_LEN) begin
            trk_len[w.pat_index] = (w.addr > 6) ? 3'd6 : w.addr[2:0];
            trk_prog[w.pat_index] = '0;
            trk_monitor[w.pat_index] = 1'b0;
         end else begin
            trk_words[w.pat_index][w.pat_slot] = w.addr;
         end
      end else if (w.op == OP_RESTART) begin
         clear_session();
         trk_pos = '0;
      end
      r.log_index = trk_pos;
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_word_type due;
      if (reset) begin
         for (int i = 0; i < 8; i++) trk_len[i] = '0;
         clear_session();
         trk_pos = '0;
         compress_on = 1'b0;
         log_words_due.delete();
         error_count = 0;
      end else begin
         if (csr_write_enable) compress_on = csr_write_data;
         if (rsp_valid && !rsp_stall) begin
            if (log_words_due.size() == 0) begin
               $error("log word with no prediction waiting: %h", rsp_word);
               error_count++;
            end else begin
               due = log_words_due.pop_front();
               if (rsp_word.log_write !== due.log_write) begin
                  $error("log_write: expected %h, got %h", due.log_write, rsp_word.log_write);
                  error_count++;
               end
               if (rsp_word.log_index !== due.log_index) begin
                  $error("log_index: expected %h, got %h", due.log_index, rsp_word.log_index);
                  error_count++;
               end
               if (rsp_word.log_value !== due.log_value) begin
                  $error("log_value: expected %h, got %h", due.log_value, rsp_word.log_value);
                  error_count++;
               end
            end
         end
         if (req_valid && !req_stall) log_words_due.push_back(log_word_for(req_word));
      end
      pending_count = log_words_due.size();
   end

endmodule

FILE: bench/tb_cfa_subpath_log_compressor_unit.sv
// Top of the sub-path log compressor testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_cfa_subpath_log_compressor_unit;
   import cfa_slc_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int OP_SPARE = 3;

   logic         clock;
   logic         reset;
   logic         csr_write_enable;
   logic         csr_write_data;
   logic         req_valid;
   logic         req_stall;
   req_word_type req_word;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_word_type rsp_word;
   int           error_count;
   int           pending_count;

   logic [31:0]  seq_words [8][6];
   int           seq_len [8];
   logic [31:0]  alphabet [12];
   logic         sender_calm;
   logic         receiver_calm;
   logic         long_hold;
   int           cycle_count;

   cfa_subpath_log_compressor_unit i_dut (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word)
   );

   cfa_subpath_log_compressor_checker i_checker (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word),
      .error_count(error_count), .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      int w;
      rsp_stall = 1'b1;
      @(negedge clock);
      forever begin
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (300) @(negedge clock);
            long_hold = 1'b0;
         end
         w = receiver_calm ? 0 : $urandom_range(0, 17);
         if (w > 0) begin
            rsp_stall <= 1'b1;
            repeat (w) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   task automatic send(input logic [1:0] op, input logic [31:0] addr,
                       input logic [2:0] index, input logic [2:0] slot);
      int w;
      w = sender_calm ? 0 : $urandom_range(0, 17);
      @(negedge clock);
      if (w > 0) begin
         req_valid <= 1'b0;
         repeat (w) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word <= '{op: op, addr: addr, pat_index: index, pat_slot: slot};
      do @(posedge clock); while (req_stall);
      if (op == OP_TABLE) begin
         if (slot == SLOT_LEN) seq_len[index] = (addr > 6) ? 6 : int'(addr);
         else if (slot < SLOT_LEN) seq_words[index][slot] = addr;
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   task automatic set_compress(input logic on);
      drain();
      repeat (4) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= on;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic play_sub_path(input int k, input int times);
      for (int t = 0; t < times; t++)
         for (int s = 0; s < seq_len[k]; s++)
            send(OP_TRACE, seq_words[k][s], 3'($urandom), 3'($urandom));
   endtask

   task automatic random_item();
      int r;
      int k;
      logic [2:0] slot;
      r = $urandom_range(0, 99);
      k = $urandom_range(0, 7);
      slot = 3'($urandom);
      if (r < 50) begin
         play_sub_path(k, $urandom_range(1, 3));
      end else if (r < 70) begin
         send(OP_TRACE, alphabet[$urandom_range(0, 11)], 3'($urandom), slot);
      end else if (r < 78) begin
         send(OP_TRACE, $urandom, 3'($urandom), slot);
      end else if (r < 90) begin
         if (slot == SLOT_LEN)
            send(OP_TABLE, ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 9),
                 3'(k), slot);
         else if (slot == SLOT_ID)
            send(OP_TABLE, ($urandom_range(0, 3) == 0) ? $urandom : 32'h100 + $urandom_range(0, 3),
                 3'(k), slot);
         else
            send(OP_TABLE, alphabet[$urandom_range(0, 11)], 3'(k), slot);
      end else if (r < 95) begin
         send(OP_RESTART, $urandom, 3'($urandom), slot);
      end else begin
         send(2'(OP_SPARE), $urandom, 3'($urandom), slot);
      end
   endtask

   initial begin
      cycle_count = 0;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = 1'b0;
      req_valid = 1'b0;
      req_word = '0;
      sender_calm = 1'b0;
      receiver_calm = 1'b0;
      long_hold = 1'b0;
      for (int i = 0; i < 12; i++) alphabet[i] = 32'h4000_0000 + 32'(i) * 4;
      for (int i = 0; i < 8; i++) seq_len[i] = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // The whole table is filled before any pattern is given a length.
      sender_calm = 1'b1;
      for (int i = 0; i < 8; i++) begin
         for (int s = 0; s < 6; s++) send(OP_TABLE, alphabet[$urandom_range(0, 11)], 3'(i), 3'(s));
         send(OP_TABLE, 32'h100 + $urandom_range(0, 3), 3'(i), SLOT_ID);
      end
      sender_calm = 1'b0;

      send(OP_TRACE, 32'h0000_0000, 3'd0, 3'd0);
      send(OP_TRACE, 32'hffff_ffff, 3'd7, 3'd7);
      send(2'(OP_SPARE), 32'hffff_ffff, 3'd7, 3'd7);
      send(OP_RESTART, 32'h0, 3'd0, 3'd0);
      send(OP_TRACE, alphabet[0], 3'd0, 3'd0);

      set_compress(1'b1);
      send(OP_TABLE, 32'd2, 3'd0, SLOT_LEN);
      send(OP_TABLE, 32'hffff_ffff, 3'd1, SLOT_LEN);
      send(OP_TABLE, 32'd0, 3'd3, SLOT_LEN);
      send(OP_TABLE, 32'd1, 3'd7, SLOT_LEN);
      play_sub_path(0, 4);
      play_sub_path(1, 2);
      play_sub_path(7, 3);
      send(OP_TRACE, 32'hffff_ffff, 3'd0, 3'd0);
      for (int i = 2; i < 7; i++) send(OP_TABLE, $urandom_range(1, 6), 3'(i), SLOT_LEN);
      send(OP_RESTART, 32'h0, 3'd0, 3'd0);
      play_sub_path(0, 2);

      for (int ph = 0; ph < 4; ph++) begin
         set_compress(ph != 1);
         for (int n = 0; n < 20; n++) begin
            sender_calm = (n >= 14);
            receiver_calm = (n >= 9 && n < 16);
            if (ph == 1 && n == 4) long_hold = 1'b1;
            if (ph == 2 && n == 9) drain();
            random_item();
         end
      end
      sender_calm = 1'b0;
      receiver_calm = 1'b0;

      drain();
      repeat (10) @(posedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+rtl
rtl/cfa_slc_pkg.sv
rtl/cfa_slc_front.sv
rtl/cfa_slc_match.sv
rtl/cfa_slc_log.sv
rtl/cfa_subpath_log_compressor_unit.sv
bench/cfa_subpath_log_compressor_checker.sv
bench/tb_cfa_subpath_log_compressor_unit.sv
